// File: rtl/rc4kc_pkg.sv
// ----------------------------------------------------------------
// RC4 keystream cipher package
// Shared types and constants for the controller and the datapath.
// ----------------------------------------------------------------
package rc4kc_pkg;

	localparam int BYTE_W     = 8;
	localparam int PERM_DEPTH = 256;
	localparam int PERM_AW    = 8;

	// kind of input beat, carried on tuser
	localparam logic OP_KEY = 1'b0;
	localparam logic OP_MSG = 1'b1;

	localparam logic [PERM_AW-1:0] LAST_INDEX = 8'hFF;

	typedef enum logic [7:0] {
		ST_IDLE    = 8'b0000_0001,
		ST_MSG_J   = 8'b0000_0010,
		ST_MSG_SW  = 8'b0000_0100,
		ST_MSG_OUT = 8'b0000_1000,
		ST_KS_RD   = 8'b0001_0000,
		ST_KS_ACC  = 8'b0010_0000,
		ST_KS_WA   = 8'b0100_0000,
		ST_KS_WB   = 8'b1000_0000
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic key_wr;      // store the key byte on the input
		logic sched_start; // restart permutation, clear schedule counters
		logic msg_start;   // latch message byte, step i, read S[i]
		logic msg_j;       // step j, read S[j]
		logic msg_sw;      // write S[i], read S[S[i]+S[j]]
		logic msg_out;     // write S[j], load result
		logic ks_rd;       // read S[n] and key byte
		logic ks_acc;      // step accumulator, read S[acc]
		logic ks_wa;       // write S[n]
		logic ks_wb;       // write S[acc], next n
		logic sched_done;  // clear indices and key count
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_free;  // result register can take a new value
		logic last_step; // schedule is on its final entry
	} sts_t;

endpackage

// File: rtl/rc4kc_ram.sv
// ----------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data (old data on
// a same-address write).
// ----------------------------------------------------------------
module rc4kc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic                                        re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/rc4kc_ctrl.sv
// ----------------------------------------------------------------
// RC4 controller
// Sequences message steps and the key schedule, issues commands.
// ----------------------------------------------------------------
module rc4kc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              s_tuser,
	input  logic              s_tlast,
	output logic              s_tready,
	input  rc4kc_pkg::sts_t   sts,
	output rc4kc_pkg::cmd_t   cmd
);

	rc4kc_pkg::state_t state_q, state_d;
	logic              accept;

	assign s_tready = (state_q == rc4kc_pkg::ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			rc4kc_pkg::ST_IDLE: begin
				if (accept) begin
					if (s_tuser == rc4kc_pkg::OP_MSG) begin
						cmd.msg_start = 1'b1;
						state_d       = rc4kc_pkg::ST_MSG_J;
					end else begin
						cmd.key_wr = 1'b1;
						if (s_tlast) begin
							cmd.sched_start = 1'b1;
							state_d         = rc4kc_pkg::ST_KS_RD;
						end
					end
				end
			end
			rc4kc_pkg::ST_MSG_J: begin
				cmd.msg_j = 1'b1;
				state_d   = rc4kc_pkg::ST_MSG_SW;
			end
			rc4kc_pkg::ST_MSG_SW: begin
				cmd.msg_sw = 1'b1;
				state_d    = rc4kc_pkg::ST_MSG_OUT;
			end
			rc4kc_pkg::ST_MSG_OUT: begin
				// hold here until the result register is free
				cmd.msg_out = 1'b1;
				if (sts.out_free) begin
					state_d = rc4kc_pkg::ST_IDLE;
				end
			end
			rc4kc_pkg::ST_KS_RD: begin
				cmd.ks_rd = 1'b1;
				state_d   = rc4kc_pkg::ST_KS_ACC;
			end
			rc4kc_pkg::ST_KS_ACC: begin
				cmd.ks_acc = 1'b1;
				state_d    = rc4kc_pkg::ST_KS_WA;
			end
			rc4kc_pkg::ST_KS_WA: begin
				cmd.ks_wa = 1'b1;
				state_d   = rc4kc_pkg::ST_KS_WB;
			end
			rc4kc_pkg::ST_KS_WB: begin
				cmd.ks_wb = 1'b1;
				if (sts.last_step) begin
					cmd.sched_done = 1'b1;
					state_d        = rc4kc_pkg::ST_IDLE;
				end else begin
					state_d = rc4kc_pkg::ST_KS_RD;
				end
			end
			default: begin
				state_d = rc4kc_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rc4kc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: rtl/rc4kc_dpath.sv
// ----------------------------------------------------------------
// RC4 datapath
// Permutation and key memories, indices, swap forwarding and the
// result register.
// ----------------------------------------------------------------
module rc4kc_dpath #(
	parameter int KEY_DEPTH = 256
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  rc4kc_pkg::cmd_t                    cmd,
	output rc4kc_pkg::sts_t                    sts,
	input  logic [rc4kc_pkg::BYTE_W-1:0]       data_in,
	input  logic                               m_tready,
	output logic                               m_tvalid,
	output logic [rc4kc_pkg::BYTE_W-1:0]       m_tdata
);

	localparam int KAW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
	localparam int CW  = $clog2(KEY_DEPTH + 1);
	localparam int BW  = rc4kc_pkg::BYTE_W;
	localparam int PAW = rc4kc_pkg::PERM_AW;

	// control state
	logic [PAW-1:0]              i_q, j_q, n_q, acc_q;
	logic [KAW-1:0]              kidx_q;
	logic [CW-1:0]               cnt_q;
	logic [rc4kc_pkg::PERM_DEPTH-1:0] vld_q;
	logic                        rvld_q;
	logic [PAW-1:0]              raddr_q;
	logic                        out_valid_q;

	// payload
	logic [BW-1:0]  data_q, si_q, sj_q, out_q;
	logic [PAW-1:0] pos_q;

	// memory ports
	logic           p_we, p_re;
	logic [PAW-1:0] p_waddr, p_raddr;
	logic [BW-1:0]  p_wdata, p_rdata, perm_rd;
	logic           k_we;
	logic [KAW-1:0] k_raddr;
	logic [BW-1:0]  k_rdata;

	logic [PAW-1:0] i_nxt, j_nxt, pos_nxt, acc_nxt;
	logic [BW-1:0]  ks;
	logic           out_load;
	logic [KAW-1:0] kidx_inc;

	rc4kc_ram #(.WIDTH(BW), .DEPTH(rc4kc_pkg::PERM_DEPTH)) u_perm (
		.clk   (clk),
		.we    (p_we),
		.waddr (p_waddr),
		.wdata (p_wdata),
		.re    (p_re),
		.raddr (p_raddr),
		.rdata (p_rdata)
	);

	rc4kc_ram #(.WIDTH(BW), .DEPTH(KEY_DEPTH)) u_key (
		.clk   (clk),
		.we    (k_we),
		.waddr (cnt_q[KAW-1:0]),
		.wdata (data_in),
		.re    (cmd.ks_rd),
		.raddr (k_raddr),
		.rdata (k_rdata)
	);

	// an entry not yet written since the last restart holds its own index
	assign perm_rd = rvld_q ? p_rdata : raddr_q;

	assign i_nxt   = i_q + PAW'(1);
	assign j_nxt   = j_q + perm_rd;
	assign pos_nxt = si_q + perm_rd;
	assign acc_nxt = acc_q + perm_rd + k_rdata;
	assign k_raddr = kidx_q;
	assign k_we    = cmd.key_wr && (cnt_q < CW'(KEY_DEPTH));
	assign kidx_inc = kidx_q + KAW'(1);

	// permutation port selection
	always_comb begin
		p_re    = 1'b0;
		p_raddr = i_nxt;
		p_we    = 1'b0;
		p_waddr = i_q;
		p_wdata = perm_rd;
		if (cmd.msg_start) begin
			p_re    = 1'b1;
			p_raddr = i_nxt;
		end
		if (cmd.msg_j) begin
			p_re    = 1'b1;
			p_raddr = j_nxt;
		end
		if (cmd.msg_sw) begin
			p_re    = 1'b1;
			p_raddr = pos_nxt;
			p_we    = 1'b1;
			p_waddr = i_q;
			p_wdata = perm_rd;
		end
		if (cmd.msg_out) begin
			p_we    = 1'b1;
			p_waddr = j_q;
			p_wdata = si_q;
		end
		if (cmd.ks_rd) begin
			p_re    = 1'b1;
			p_raddr = n_q;
		end
		if (cmd.ks_acc) begin
			p_re    = 1'b1;
			p_raddr = acc_nxt;
		end
		if (cmd.ks_wa) begin
			p_we    = 1'b1;
			p_waddr = n_q;
			p_wdata = perm_rd;
		end
		if (cmd.ks_wb) begin
			p_we    = 1'b1;
			p_waddr = acc_q;
			p_wdata = si_q;
		end
	end

	// keystream byte: forward the swapped values, as the read returns S[pos] from before the swap
	always_comb begin
		if (pos_q == j_q) begin
			ks = si_q;
		end else if (pos_q == i_q) begin
			ks = sj_q;
		end else begin
			ks = perm_rd;
		end
	end

	assign out_load      = cmd.msg_out && sts.out_free;
	assign sts.out_free  = !out_valid_q || m_tready;
	assign sts.last_step = (n_q == rc4kc_pkg::LAST_INDEX);
	assign m_tvalid      = out_valid_q;
	assign m_tdata       = out_q;

	// indices, counters and valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q         <= '0;
			j_q         <= '0;
			n_q         <= '0;
			acc_q       <= '0;
			kidx_q      <= '0;
			cnt_q       <= '0;
			vld_q       <= '0;
			rvld_q      <= 1'b0;
			raddr_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (p_re) begin
				rvld_q  <= vld_q[p_raddr];
				raddr_q <= p_raddr;
			end
			if (p_we) begin
				vld_q[p_waddr] <= 1'b1;
			end
			if (k_we) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (cmd.msg_start) begin
				i_q <= i_nxt;
			end
			if (cmd.msg_j) begin
				j_q <= j_nxt;
			end
			if (cmd.sched_start) begin
				vld_q  <= '0;
				n_q    <= '0;
				acc_q  <= '0;
				kidx_q <= '0;
			end
			if (cmd.ks_acc) begin
				acc_q <= acc_nxt;
			end
			if (cmd.ks_wb) begin
				n_q <= n_q + PAW'(1);
				// key index wraps at the stored key length
				if (CW'(kidx_inc) == cnt_q || kidx_inc == '0) begin
					kidx_q <= '0;
				end else begin
					kidx_q <= kidx_inc;
				end
			end
			if (cmd.sched_done) begin
				i_q   <= '0;
				j_q   <= '0;
				cnt_q <= '0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.msg_start) begin
			data_q <= data_in;
		end
		if (cmd.msg_j || cmd.ks_acc) begin
			si_q <= perm_rd;
		end
		if (cmd.msg_sw) begin
			sj_q  <= perm_rd;
			pos_q <= pos_nxt;
		end
		if (out_load) begin
			out_q <= data_q ^ ks;
		end
	end

endmodule

// File: rtl/rc4_keystream_cipher.sv
// m_tvalid rises after an accepted message beat has passed the MSG_J, MSG_SW and MSG_OUT
// states, later under stall. A new beat is taken only back in IDLE, after the chain of
// dependent reads and writes on the permutation memory (one read, one write port).
// A plain key byte leaves the input ready; the last key byte starts the key schedule,
// KS_RD, KS_ACC, KS_WA and KS_WB per entry, 256 entries. Reset (arst_n, async, active low)
// restores the identity permutation at once via per-entry valid bits; no clearing pass.
// ----------------------------------------------------------------
// RC4 keystream cipher
// Stores key bytes, runs the key schedule on the flagged last key byte
// and XORs message bytes with the generated keystream.
// ----------------------------------------------------------------
module rc4_keystream_cipher #(
	parameter int KEY_DEPTH = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,  // [7:0] data_byte
	input  logic       s_tuser,  // [0] operation
	input  logic       s_tlast,  // key_end
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata   // [7:0] cipher_byte
);

	rc4kc_pkg::cmd_t cmd;
	rc4kc_pkg::sts_t sts;

	rc4kc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rc4kc_dpath #(.KEY_DEPTH(KEY_DEPTH)) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.data_in  (s_tdata),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata)
	);

endmodule

// File: rtl/rc4kc_checker.sv
// ----------------------------------------------------------------
// RC4 port checker
// Port-level checks of handshake and sequencing, bound to the top.
// ----------------------------------------------------------------
module rc4kc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       s_tuser,
	input logic       s_tlast,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata
);

	logic acc_key, acc_msg;

	assign acc_key = s_tvalid && s_tready && (s_tuser == rc4kc_pkg::OP_KEY);
	assign acc_msg = s_tvalid && s_tready && (s_tuser == rc4kc_pkg::OP_MSG);

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat dropped or changed while stalled");

	// plain key byte: input ready again in the next cycle
	a_key_fast: assert property (@(posedge clk) disable iff (!arst_n)
		acc_key && !s_tlast |=> s_tready)
		else $error("not ready after plain key byte");

	// message beat keeps the block busy
	a_msg_busy: assert property (@(posedge clk) disable iff (!arst_n)
		acc_msg |=> !s_tready)
		else $error("ready right after message beat");

	// key schedule keeps input blocked
	a_sched_busy: assert property (@(posedge clk) disable iff (!arst_n)
		acc_key && s_tlast |-> ##16 !s_tready)
		else $error("input ready during key schedule");

endmodule

bind rc4_keystream_cipher rc4kc_checker u_rc4kc_checker (.*);

// File: dv/tb_rc4_keystream_cipher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------
// RC4 keystream cipher testbench
// Drives key and message beats through the stream ports with random
// gaps and backpressure. A local RC4 predictor follows every accepted
// beat, and each cipher byte that comes out is checked in order.
// ----------------------------------------------------------------
module tb_rc4_keystream_cipher;

	localparam int KEY_DEPTH   = 256;
	localparam int STALL_LIMIT = 8000;
	localparam int MAX_SHOWN   = 10;

	logic       clk      = 1'b0;
	logic       arst_n   = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata  = 8'h00; // [7:0] data_byte
	logic       s_tuser  = rc4kc_pkg::OP_KEY; // [0] operation
	logic       s_tlast  = 1'b0;  // key_end
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;          // [7:0] cipher_byte

	// predictor state
	logic [7:0]  perm_s [rc4kc_pkg::PERM_DEPTH];
	logic [7:0]  key_bytes [KEY_DEPTH];
	int unsigned key_len;
	logic [7:0]  gen_i;
	logic [7:0]  gen_j;
	logic [7:0]  cipher_q [$];

	bit          idle_en = 1'b0;
	int unsigned fault_count = 0;
	int unsigned sink_hold = 0;
	int unsigned stall_cycles;

	rc4_keystream_cipher #(
		.KEY_DEPTH(KEY_DEPTH)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always #2 clk = ~clk;

	// ---------------- predictor ----------------

	function automatic void rc4_clear_state();
		for (int n = 0; n < rc4kc_pkg::PERM_DEPTH; n++) begin
			perm_s[n] = n[7:0];
		end
		for (int n = 0; n < KEY_DEPTH; n++) begin
			key_bytes[n] = 8'h00;
		end
		key_len = 0;
		gen_i   = 8'h00;
		gen_j   = 8'h00;
	endfunction

	// key schedule from the identity permutation over the stored key
	function automatic void rc4_schedule();
		logic [7:0] acc;
		logic [7:0] kb;
		logic [7:0] tmp;
		acc = 8'h00;
		for (int n = 0; n < rc4kc_pkg::PERM_DEPTH; n++) begin
			perm_s[n] = n[7:0];
		end
		for (int n = 0; n < rc4kc_pkg::PERM_DEPTH; n++) begin
			kb  = (key_len > 0) ? key_bytes[n % key_len] : 8'h00;
			acc = acc + perm_s[n] + kb;
			tmp = perm_s[n];
			perm_s[n] = perm_s[acc];
			perm_s[acc] = tmp;
		end
		gen_i   = 8'h00;
		gen_j   = 8'h00;
		key_len = 0;
	endfunction

	function automatic void rc4_predict(input logic op, input logic [7:0] data,
			input logic kend);
		logic [7:0] tmp;
		logic [7:0] pos;
		if (op == rc4kc_pkg::OP_KEY) begin
			// bytes past the store depth are dropped, the end flag still counts
			if (key_len < KEY_DEPTH) begin
				key_bytes[key_len] = data;
				key_len++;
			end
			if (kend) begin
				rc4_schedule();
			end
		end else begin
			gen_i = gen_i + 8'd1;
			gen_j = gen_j + perm_s[gen_i];
			tmp = perm_s[gen_i];
			perm_s[gen_i] = perm_s[gen_j];
			perm_s[gen_j] = tmp;
			pos = perm_s[gen_i] + perm_s[gen_j];
			cipher_q.push_back(data ^ perm_s[pos]);
		end
	endfunction

	function automatic void log_fault(input string msg);
		fault_count++;
		if (fault_count <= MAX_SHOWN) begin
			$display("[%0t] ERROR: %s", $realtime, msg);
		end
	endfunction

	// ---------------- driver ----------------

	// one input beat; returns at the edge where it was accepted
	task automatic send_beat(input logic op, input logic [7:0] data, input logic kend);
		bit took;
		if (idle_en && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= data;
		s_tlast  <= kend;
		do begin
			@(negedge clk);
			took = s_tready;
			@(posedge clk);
		end while (!took);
		rc4_predict(op, data, kend);
	endtask

	task automatic send_key(input int unsigned len);
		for (int unsigned k = 0; k < len; k++) begin
			send_beat(rc4kc_pkg::OP_KEY, 8'($urandom), k == len - 1);
		end
	endtask

	task automatic send_msgs(input int unsigned len);
		for (int unsigned k = 0; k < len; k++) begin
			send_beat(rc4kc_pkg::OP_MSG, 8'($urandom), $urandom_range(0, 7) == 0);
		end
	endtask

	// ---------------- sink and checker ----------------

	// output backpressure in bursts
	always @(posedge clk) begin
		if (!idle_en) begin
			m_tready <= 1'b1;
		end else if (sink_hold > 0) begin
			sink_hold = sink_hold - 1;
			m_tready <= 1'b0;
		end else if ($urandom_range(0, 5) == 0) begin
			sink_hold = $urandom_range(1, 8) - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// a beat seen here is taken at the next rising edge
	always @(negedge clk) begin
		logic [7:0] exp_byte;
		if (arst_n && m_tvalid && m_tready) begin
			if (cipher_q.size() == 0) begin
				log_fault($sformatf("cipher byte %02h with none pending", m_tdata));
			end else begin
				exp_byte = cipher_q.pop_front();
				if (m_tdata !== exp_byte) begin
					log_fault($sformatf("cipher_byte mismatch: expected %02h, got %02h",
						exp_byte, m_tdata));
				end
			end
		end
	end

	// ends the run when no beat moves for too long
	initial begin : watchdog
		stall_cycles = 0;
		while (stall_cycles < STALL_LIMIT) begin
			@(negedge clk);
			if (arst_n && !((s_tvalid && s_tready) || (m_tvalid && m_tready))) begin
				stall_cycles++;
			end else begin
				stall_cycles = 0;
			end
		end
		$display("[%0t] ERROR: no beat moved for %0d cycles", $realtime, STALL_LIMIT);
		$display("rc4_keystream_cipher regression: fail");
		$finish;
	end

	// ---------------- tests ----------------

	// generator on the identity permutation right after reset
	task automatic test_generator_after_reset();
		send_beat(rc4kc_pkg::OP_MSG, 8'h00, 1'b0);
		send_beat(rc4kc_pkg::OP_MSG, 8'hFF, 1'b0);
		send_beat(rc4kc_pkg::OP_MSG, 8'hA5, 1'b1); // end flag on a message is ignored
		send_beat(rc4kc_pkg::OP_MSG, 8'h5A, 1'b0);
	endtask

	// single-byte keys at both extremes
	task automatic test_single_byte_keys();
		send_beat(rc4kc_pkg::OP_KEY, 8'h00, 1'b1);
		send_beat(rc4kc_pkg::OP_MSG, 8'h00, 1'b0);
		send_beat(rc4kc_pkg::OP_MSG, 8'hFF, 1'b0);
		send_beat(rc4kc_pkg::OP_MSG, 8'h3C, 1'b0);
		send_beat(rc4kc_pkg::OP_KEY, 8'hFF, 1'b1);
		send_beat(rc4kc_pkg::OP_MSG, 8'hFF, 1'b0);
		send_beat(rc4kc_pkg::OP_MSG, 8'h00, 1'b1);
	endtask

	// key bytes between messages only get stored until the end flag
	task automatic test_key_mid_stream();
		send_beat(rc4kc_pkg::OP_KEY, 8'h01, 1'b0);
		send_beat(rc4kc_pkg::OP_KEY, 8'h80, 1'b1);
		send_beat(rc4kc_pkg::OP_MSG, 8'h11, 1'b0);
		send_beat(rc4kc_pkg::OP_MSG, 8'h22, 1'b0);
		send_beat(rc4kc_pkg::OP_KEY, 8'h12, 1'b0);
		send_beat(rc4kc_pkg::OP_KEY, 8'h34, 1'b0);
		send_beat(rc4kc_pkg::OP_MSG, 8'h33, 1'b0);
		send_beat(rc4kc_pkg::OP_MSG, 8'h44, 1'b0);
		send_beat(rc4kc_pkg::OP_KEY, 8'h56, 1'b1);
		send_beat(rc4kc_pkg::OP_MSG, 8'h55, 1'b0);
		send_beat(rc4kc_pkg::OP_MSG, 8'h66, 1'b0);
		send_beat(rc4kc_pkg::OP_MSG, 8'h77, 1'b0);
	endtask

	// key longer than the store: the excess is dropped
	task automatic test_overlong_key();
		send_key(KEY_DEPTH + $urandom_range(1, 8));
		send_msgs(8);
	endtask

	// full-depth key, exactly filling the store
	task automatic test_full_depth_key();
		send_key(KEY_DEPTH);
		send_msgs(6);
	endtask

	// sender holds off until every pending result has drained
	task automatic test_drain_pause();
		send_msgs(6);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (cipher_q.size() != 0) @(posedge clk);
		send_msgs(6);
	endtask

	// mostly keyed sessions, with stray messages and stray key bytes mixed in
	task automatic test_random_sessions(input int unsigned budget, input bit with_idle);
		int unsigned sent;
		int unsigned klen;
		int unsigned mlen;
		idle_en = with_idle;
		sent = 0;
		while (sent < budget) begin
			case ($urandom_range(0, 9))
				0: begin
					mlen = $urandom_range(1, 10);
					send_msgs(mlen);
					sent += mlen;
				end
				1: begin
					// no end flag: these lead the next key
					klen = $urandom_range(1, 6);
					for (int unsigned k = 0; k < klen; k++) begin
						send_beat(rc4kc_pkg::OP_KEY, 8'($urandom), 1'b0);
					end
					sent += klen;
				end
				default: begin
					klen = ($urandom_range(0, 24) == 0) ? $urandom_range(200, KEY_DEPTH)
						: $urandom_range(1, 16);
					mlen = $urandom_range(1, 40);
					send_key(klen);
					send_msgs(mlen);
					sent += klen + mlen;
				end
			endcase
		end
	endtask

	initial begin
		rc4_clear_state();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_en = 1'b1;
		test_generator_after_reset();
		test_single_byte_keys();
		test_key_mid_stream();
		test_overlong_key();
		test_full_depth_key();
		test_drain_pause();
		test_random_sessions(260, 1'b1);
		test_random_sessions(120, 1'b0);
		test_random_sessions(120, 1'b1);
		test_random_sessions(90, 1'b0);

		s_tvalid <= 1'b0;
		while (cipher_q.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);

		if (fault_count == 0) begin
			$display("rc4_keystream_cipher regression: pass");
		end else begin
			$display("rc4_keystream_cipher regression: fail");
		end
		$finish;
	end

endmodule

// File: sim.f
rtl/rc4kc_pkg.sv
rtl/rc4kc_ram.sv
rtl/rc4kc_ctrl.sv
rtl/rc4kc_dpath.sv
rtl/rc4_keystream_cipher.sv
rtl/rc4kc_checker.sv
dv/tb_rc4_keystream_cipher.sv
